>>> rtl/core/dad_pkg.sv
// Package for the date-plus-days core: beat types, state codes and the month length table.
`default_nettype none
package dad_pkg;

    typedef struct packed {
        logic [13:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [15:0] add_days;
    } t_date_in;

    typedef struct packed {
        logic [13:0] result_year;
        logic [3:0]  result_month;
        logic [4:0]  result_day;
        logic        input_invalid;
        logic        year_overflow;
    } t_date_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MOD,
        S_CHECK,
        S_CYC,
        S_ADD,
        S_MONTH,
        S_DONE
    } t_state;

    localparam logic [3:0]  MONTH_JAN     = 4'd1;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;
    localparam logic [4:0]  DAY_SAT       = 5'd31;
    localparam int          DAYS_PER_400Y = 146097;
    localparam int          YEARS_PER_CYC = 400;
    // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
    localparam logic [12:0] RECIP_100     = 13'd5243;
    localparam int          RECIP_SHIFT   = 19;
    localparam logic [6:0]  CENTURY       = 7'd100;
    localparam logic [6:0]  CENTURY_LAST  = 7'd99;

    // Month length; zero for codes that are not a month.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/date_add_days_core.sv
// Gregorian date plus day count: sequenced core around one shared add/subtract unit.
//
//  channel | ports                    | handshake
//  --------+--------------------------+-----------------------------------------
//  item in | i_item, start, busy      | beat taken on edge with start && !busy
//  result  | o_result, o_strobe       | one-cycle strobe, no back-pressure
//
// Steps: accept, split the year into its mod-4/100/400 residues, check the date,
// take off whole 400-year blocks, add the day count, step month by month through
// the shared subtractor, then give the result. Invalid dates go from the check
// straight to the result strobe. busy is high from accept to strobe.
// Synchronous active-low reset returns the sequencer to idle; no clearing pass.
`default_nettype none
module date_add_days_core #(
    parameter int MAX_YEAR      = 9999,
    parameter int ADD_DAYS_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  dad_pkg::t_date_in i_item,
    output logic              busy,
    output logic              o_strobe,
    output dad_pkg::t_date_out o_result
);
    import dad_pkg::*;

    localparam int YMAX = (MAX_YEAR > 16383) ? MAX_YEAR : 16383;
    localparam int YW   = $clog2(YMAX + YEARS_PER_CYC + 2);
    localparam int NW   = ADD_DAYS_BITS;
    localparam int DW   = ((ADD_DAYS_BITS > 5) ? ADD_DAYS_BITS : 5) + 1;
    localparam int AW   = (DW > 18) ? DW : 18;

    localparam logic [YW-1:0] MAX_Y   = YW'(MAX_YEAR);
    localparam logic [YW-1:0] CYC_Y   = YW'(YEARS_PER_CYC);
    localparam logic [AW-1:0] CYC_D   = AW'(DAYS_PER_400Y);
    localparam logic [13:0]   SAT_Y   = 14'(MAX_YEAR);

    t_state r_state, n_state;

    logic [YW-1:0] r_year,  n_year;
    logic [3:0]    r_month, n_month;
    logic [DW-1:0] r_day,   n_day;
    logic [NW-1:0] r_cnt,   n_cnt;
    logic [7:0]    r_quot,  n_quot;
    logic [1:0]    r_m4,    n_m4;
    logic [6:0]    r_m100,  n_m100;
    logic [1:0]    r_q4,    n_q4;
    logic          r_inv,   n_inv;
    logic          r_ovf,   n_ovf;

    logic [31:0]   add_wide;
    logic [26:0]   prod;
    logic [13:0]   hundreds;
    logic          leap;
    logic [4:0]    len;
    logic [AW-1:0] op_a, op_b;
    logic          op_sub;
    logic [AW:0]   sum;
    logic          borrow;
    logic          gt;
    logic [YW-1:0] year_inc, year_cyc;

    assign add_wide = 32'(i_item.add_days);
    assign prod     = 27'(r_year[13:0]) * 27'(RECIP_100);
    assign hundreds = 14'(r_quot) * 14'(CENTURY);
    assign leap     = ((r_m4 == 2'd0) && (r_m100 != 7'd0)) ||
                      ((r_m100 == 7'd0) && (r_q4 == 2'd0));
    assign len      = month_len(r_month, leap);
    assign year_inc = r_year + YW'(1);
    assign year_cyc = r_year + CYC_Y;

    // shared add/subtract unit
    always_comb begin
        op_a   = AW'(r_day);
        op_b   = AW'(len);
        op_sub = 1'b1;
        case (r_state)
            S_CYC: begin
                op_a = AW'(r_cnt);
                op_b = CYC_D;
            end
            S_ADD: begin
                op_b   = AW'(r_cnt);
                op_sub = 1'b0;
            end
            default: ;
        endcase
        sum = op_sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});
    end

    assign borrow = sum[AW];
    assign gt     = !borrow && (sum[AW-1:0] != '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_DIV;
            S_DIV:   n_state = S_MOD;
            S_MOD:   n_state = S_CHECK;
            S_CHECK: begin
                if (r_day == '0 || gt || r_year > MAX_Y) n_state = S_DONE;
                else                                     n_state = S_CYC;
            end
            S_CYC: begin
                if (borrow)                n_state = S_ADD;
                else if (year_cyc > MAX_Y) n_state = S_DONE;
            end
            S_ADD:   n_state = S_MONTH;
            S_MONTH: begin
                if (!gt)                                          n_state = S_DONE;
                else if (r_month == MONTH_DEC && year_inc > MAX_Y) n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_cnt   = r_cnt;
        n_quot  = r_quot;
        n_m4    = r_m4;
        n_m100  = r_m100;
        n_q4    = r_q4;
        n_inv   = r_inv;
        n_ovf   = r_ovf;
        case (r_state)
            S_IDLE: begin
                n_year  = YW'(i_item.start_year);
                n_month = i_item.start_month;
                n_day   = DW'(i_item.start_day);
                n_cnt   = add_wide[NW-1:0];
                n_inv   = 1'b0;
                n_ovf   = 1'b0;
            end
            S_DIV: n_quot = prod[RECIP_SHIFT+7:RECIP_SHIFT];
            S_MOD: begin
                n_m100 = 7'(14'(r_year) - hundreds);
                n_q4   = r_quot[1:0];
                n_m4   = r_year[1:0];
            end
            S_CHECK: begin
                if (r_day == '0 || gt) n_inv = 1'b1;
                else if (r_year > MAX_Y) n_ovf = 1'b1;
            end
            S_CYC: begin
                // a whole 400-year block keeps month, day and leap residues
                if (!borrow) begin
                    n_cnt  = sum[NW-1:0];
                    n_year = year_cyc;
                    if (year_cyc > MAX_Y) n_ovf = 1'b1;
                end
            end
            S_ADD: n_day = sum[DW-1:0];
            S_MONTH: begin
                if (gt) begin
                    n_day = sum[DW-1:0];
                    if (r_month == MONTH_DEC) begin
                        n_month = MONTH_JAN;
                        n_year  = year_inc;
                        n_m4    = r_m4 + 2'd1;
                        if (r_m100 == CENTURY_LAST) begin
                            n_m100 = 7'd0;
                            n_q4   = r_q4 + 2'd1;
                        end else begin
                            n_m100 = r_m100 + 7'd1;
                        end
                        if (year_inc > MAX_Y) n_ovf = 1'b1;
                    end else begin
                        n_month = r_month + 4'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_cnt   <= n_cnt;
        r_quot  <= n_quot;
        r_m4    <= n_m4;
        r_m100  <= n_m100;
        r_q4    <= n_q4;
        r_inv   <= n_inv;
        r_ovf   <= n_ovf;
    end

    // outputs
    always_comb begin
        busy     = (r_state != S_IDLE);
        o_strobe = (r_state == S_DONE);
        o_result.input_invalid = r_inv;
        o_result.year_overflow = r_ovf;
        if (r_ovf) begin
            o_result.result_year  = SAT_Y;
            o_result.result_month = MONTH_DEC;
            o_result.result_day   = DAY_SAT;
        end else begin
            o_result.result_year  = r_year[13:0];
            o_result.result_month = r_month;
            o_result.result_day   = r_day[4:0];
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held past one cycle");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.input_invalid && o_result.year_overflow))
        else $error("invalid and overflow flagged together");

    a_valid_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.input_invalid && !o_result.year_overflow) |->
        (o_result.result_month >= MONTH_JAN && o_result.result_month <= MONTH_DEC &&
         o_result.result_day != 5'd0))
        else $error("valid result is not a calendar date");

    a_idle_after_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy)
        else $error("core not free after result beat");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Testbench for date_add_days_core: directed table then random dates, checked against table values or a date predictor.
`timescale 1ns / 1ps
module tb_top;
    import dad_pkg::*;

    localparam int MAX_YR    = 9999;
    localparam int DAY_BITS  = 16;
    localparam int N_ROWS    = 25;
    localparam int N_RANDOM  = 725;
    localparam bit BY_TABLE  = 1'b1;
    localparam bit BY_MODEL  = 1'b0;

    typedef struct {
        t_date_in  beat;
        bit        typed;
        t_date_out want;
    } t_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_date_in  i_item  = '0;
    logic      busy;
    logic      o_strobe;
    t_date_out o_result;

    t_date_out due_q[$];
    t_row      plan[N_ROWS];
    int        err_cnt = 0;
    bit        quiet   = 1'b0;

    int unsigned mdays[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    date_add_days_core #(
        .MAX_YEAR      (MAX_YR),
        .ADD_DAYS_BITS (DAY_BITS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #6 i_clk = ~i_clk;

    function automatic int days_in_month(input int y, input int m);
        int len;
        if (m < 1 || m > 12)
            return 0;
        len = mdays[m];
        if (m == MONTH_FEB && (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)))
            len = len + 1;
        return len;
    endfunction

    function automatic t_date_out date_after(input t_date_in beat);
        t_date_out r;
        int        y, m, d, n, blocks, len;
        r = '0;
        y = beat.start_year;
        m = beat.start_month;
        d = beat.start_day;
        n = beat.add_days;
        if (m < 1 || m > 12 || d < 1 || d > days_in_month(y, m)) begin
            r.input_invalid = 1'b1;
        end else begin
            // whole 400-year blocks leave month and day alone
            blocks = n / DAYS_PER_400Y;
            y      = y + YEARS_PER_CYC * blocks;
            d      = d + n - blocks * DAYS_PER_400Y;
            len    = days_in_month(y, m);
            while (d > len) begin
                d = d - len;
                m = m + 1;
                if (m > MONTH_DEC) begin
                    m = MONTH_JAN;
                    y = y + 1;
                end
                len = days_in_month(y, m);
            end
            if (y > MAX_YR) begin
                r.year_overflow = 1'b1;
                y = MAX_YR;
                m = MONTH_DEC;
                d = DAY_SAT;
            end
        end
        r.result_year  = 14'(y);
        r.result_month = 4'(m);
        r.result_day   = 5'(d);
        return r;
    endfunction

    function automatic t_row mk(input int y, input int m, input int d, input int n,
                                input bit typed, input int ry, input int rm, input int rd,
                                input bit inv, input bit ovf);
        t_row row;
        row.beat  = '{start_year: 14'(y), start_month: 4'(m), start_day: 5'(d),
                      add_days: 16'(n)};
        row.typed = typed;
        row.want  = '{result_year: 14'(ry), result_month: 4'(rm), result_day: 5'(rd),
                      input_invalid: inv, year_overflow: ovf};
        return row;
    endfunction

    function automatic t_date_in rand_date();
        t_date_in beat;
        int       y, m, d, len, pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            y = $urandom_range(0, 16383);
        else if (pick < 25)
            y = $urandom_range(9800, MAX_YR);
        else
            y = $urandom_range(1, MAX_YR);
        m   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
        len = days_in_month(y, m);
        d   = (len == 0 || $urandom_range(0, 99) < 12) ? $urandom_range(0, 31)
                                                       : $urandom_range(1, len);
        beat.start_year  = 14'(y);
        beat.start_month = 4'(m);
        beat.start_day   = 5'(d);
        // long counts step through thousands of months, so keep most of them short
        pick = $urandom_range(0, 99);
        if (pick < 85)
            beat.add_days = 16'($urandom_range(0, 400));
        else if (pick < 95)
            beat.add_days = 16'($urandom_range(0, 4095));
        else
            beat.add_days = 16'($urandom_range(0, 65535));
        return beat;
    endfunction

    // Present one beat, hold it until taken, queue what it should give.
    task automatic send_beat(input t_date_in beat, input bit typed, input t_date_out want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= beat;
        do @(posedge i_clk); while (busy);
        due_q.push_back(typed ? want : date_after(beat));
    endtask

    always @(posedge i_clk) begin
        t_date_out want;
        if (i_rst_n && o_strobe) begin
            if (due_q.size() == 0) begin
                $error("result beat with nothing outstanding: %p", o_result);
                err_cnt++;
            end else begin
                want = due_q.pop_front();
                if (o_result.result_year !== want.result_year) begin
                    $error("result_year: expected %0d, got %0d",
                           want.result_year, o_result.result_year);
                    err_cnt++;
                end
                if (o_result.result_month !== want.result_month) begin
                    $error("result_month: expected %0d, got %0d",
                           want.result_month, o_result.result_month);
                    err_cnt++;
                end
                if (o_result.result_day !== want.result_day) begin
                    $error("result_day: expected %0d, got %0d",
                           want.result_day, o_result.result_day);
                    err_cnt++;
                end
                if (o_result.input_invalid !== want.input_invalid) begin
                    $error("input_invalid: expected %0d, got %0d",
                           want.input_invalid, o_result.input_invalid);
                    err_cnt++;
                end
                if (o_result.year_overflow !== want.year_overflow) begin
                    $error("year_overflow: expected %0d, got %0d",
                           want.year_overflow, o_result.year_overflow);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        t_date_out none;
        none = '0;
        plan[0]  = mk(2024,  1,  1,     0, BY_TABLE, 2024,  1,  1, 0, 0);
        plan[1]  = mk(2023,  0, 15,   100, BY_TABLE, 2023,  0, 15, 1, 0);
        plan[2]  = mk(2023, 13, 10,     5, BY_TABLE, 2023, 13, 10, 1, 0);
        plan[3]  = mk(2023, 15, 31,     1, BY_TABLE, 2023, 15, 31, 1, 0);
        plan[4]  = mk(2023,  5,  0,    10, BY_TABLE, 2023,  5,  0, 1, 0);
        plan[5]  = mk(2023,  2, 29,     0, BY_TABLE, 2023,  2, 29, 1, 0);
        plan[6]  = mk(2024,  2, 29,     0, BY_TABLE, 2024,  2, 29, 0, 0);
        plan[7]  = mk(1900,  2, 29,     3, BY_TABLE, 1900,  2, 29, 1, 0);
        plan[8]  = mk(2000,  2, 29,     1, BY_TABLE, 2000,  3,  1, 0, 0);
        plan[9]  = mk(2023,  4, 31,     0, BY_TABLE, 2023,  4, 31, 1, 0);
        plan[10] = mk(2023, 12, 31,     1, BY_TABLE, 2024,  1,  1, 0, 0);
        plan[11] = mk(9999, 12, 31,     1, BY_TABLE, 9999, 12, 31, 0, 1);
        plan[12] = mk(16383, 1,  1,     0, BY_TABLE, 9999, 12, 31, 0, 1);
        plan[13] = mk(   0,  1,  1,     0, BY_TABLE,    0,  1,  1, 0, 0);
        plan[14] = mk(   0,  2, 29,     0, BY_TABLE,    0,  2, 29, 0, 0);
        plan[15] = mk(   0,  1,  1, 65535, BY_MODEL,    0,  0,  0, 0, 0);
        plan[16] = mk(2024,  2, 28,     1, BY_TABLE, 2024,  2, 29, 0, 0);
        plan[17] = mk(2023,  2, 28,     1, BY_TABLE, 2023,  3,  1, 0, 0);
        plan[18] = mk(9000,  6, 15, 65535, BY_MODEL,    0,  0,  0, 0, 0);
        plan[19] = mk(9900,  1,  1, 65535, BY_TABLE, 9999, 12, 31, 0, 1);
        plan[20] = mk(2100,  2, 28,     1, BY_TABLE, 2100,  3,  1, 0, 0);
        plan[21] = mk(1999, 12, 31,   366, BY_MODEL,    0,  0,  0, 0, 0);
        plan[22] = mk(2023,  1, 31,    31, BY_MODEL,    0,  0,  0, 0, 0);
        plan[23] = mk(16383, 15, 31, 65535, BY_TABLE, 16383, 15, 31, 1, 0);
        plan[24] = mk(2023,  6, 30, 65535, BY_MODEL,    0,  0,  0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i])
            send_beat(plan[i].beat, plan[i].typed, plan[i].want);

        for (int k = 0; k < N_RANDOM; k++) begin
            // runs of back-to-back beats now and then
            if (k % 50 == 0)
                quiet = ($urandom_range(0, 9) < 3);
            send_beat(rand_date(), BY_MODEL, none);
        end
        start <= 1'b0;

        while (due_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/dad_pkg.sv
rtl/core/date_add_days_core.sv
tb/tb_top.sv
